/* rtl/core/pcg_pkg.sv */
package pcg_pkg;

  // Configuration register map, one 32-bit register every four bytes.
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_START_FREQ   = 3'd0,
    REG_STOP_FREQ    = 3'd1,
    REG_SWEEP_RATE   = 3'd2,
    REG_PULSE_WIDTH  = 3'd3,
    REG_PULSE_PERIOD = 3'd4,
    REG_SWEEP_MODE   = 3'd5,
    REG_GAIN         = 3'd6,
    REG_MIX_ENABLE   = 3'd7
  } cfg_reg_t;

  // Frequency word: Q32.16 signed, 48 bits.
  localparam int FREQ_BITS      = 48;
  localparam int FREQ_FRAC_BITS = 16;
  localparam int GAIN_BITS      = 15;

  // pi/2 in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave sine entry k of a table with 2^tib steps, scaled to full_scale.
  // The sine comes from a truncated integer Taylor series up to x^17 in Q30.
  function automatic logic [63:0] qtab_entry(input int k, input int tib,
                                             input logic [63:0] full_scale);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      sum;
    longint      v;
    x   = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tib - 1))) >> tib;
    x2  = (x * x) >> 30;
    t   = x;
    sum = longint'(x);
    t = ((t * x2) >> 30) / 64'd6;   sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd20;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd42;  sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd72;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd110; sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd156; sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd210; sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd272; sum = sum + longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * longint'(full_scale) + (longint'(1) << 29)) >>> 30;
    if (v > longint'(full_scale)) begin
      v = longint'(full_scale);
    end
    return 64'(v);
  endfunction

endpackage

/* rtl/core/pulsed_chirp_generator_top.sv */
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  tdata: in_re, in_im; tlast: block_end
// m_*       out        m_tvalid/m_tready  tdata: out_re, out_im
// apb       in/out     psel/penable       eight 32-bit registers at 4*index
//
// One word is taken per clock while the output is not stalled; each result passes
// table read, gain multiply, then mix and saturate, each behind a register.
// Sweep, phase and pulse state advance in the cycle a word is accepted while armed.
// Reset is synchronous; after it the block is unarmed and passes samples through.
// A stalled output holds only the stages behind it that are full; empty stages
// keep taking words.
module pulsed_chirp_generator_top #(
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16,
  parameter int TABLE_INDEX_BITS = 10
) (
  input  logic clk,
  input  logic rst,

  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // in_re, in_im from bit 0 up, zero padded to whole bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
  // block_end
  input  logic                                    s_tlast,

  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // out_re, out_im from bit 0 up, zero padded to whole bytes
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,

  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [pcg_pkg::CFG_ADDR_BITS-1:0]       paddr,
  input  logic [pcg_pkg::CFG_DATA_BITS-1:0]       pwdata,
  output logic [pcg_pkg::CFG_DATA_BITS-1:0]       prdata,
  output logic                                    pready
);
  import pcg_pkg::*;

  localparam int DATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int MAG_BITS  = SAMPLE_BITS - 1;
  localparam int QN        = 1 << TABLE_INDEX_BITS;
  localparam int PROD_BITS = MAG_BITS + GAIN_BITS + 1;
  localparam logic [63:0] FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic signed [SAMPLE_BITS:0] SAT_MAX = (SAMPLE_BITS+1)'(FULL_SCALE);
  localparam logic signed [SAMPLE_BITS:0] SAT_MIN = -SAT_MAX - 1;
  localparam logic signed [FREQ_BITS-1:0] F_MAX = {1'b0, {(FREQ_BITS-1){1'b1}}};
  localparam logic signed [FREQ_BITS-1:0] F_MIN = {1'b1, {(FREQ_BITS-1){1'b0}}};

  typedef logic [MAG_BITS-1:0] qtab_t [0:QN];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k <= QN; k++) begin
      tab[k] = MAG_BITS'(qtab_entry(k, TABLE_INDEX_BITS, FULL_SCALE));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Configuration registers
  logic signed [31:0]     start_freq;
  logic signed [31:0]     stop_freq;
  logic signed [31:0]     sweep_rate;
  logic [31:0]            pulse_width;
  logic [31:0]            pulse_period;
  logic                   sweep_mode;
  logic [GAIN_BITS-1:0]   gain;
  logic                   mix_enable;

  // Generator state
  logic                        armed;
  logic [PHASE_BITS-1:0]       phase_acc;
  logic signed [FREQ_BITS-1:0] current_freq;
  logic                        ramp_active;
  logic [31:0]                 pulse_count;

  logic     cfg_wr;
  cfg_reg_t cfg_idx;
  logic     accept;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);

  // Register writes; every write restarts the sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_freq   <= '0;
      stop_freq    <= '0;
      sweep_rate   <= '0;
      pulse_width  <= '0;
      pulse_period <= '0;
      sweep_mode   <= 1'b0;
      gain         <= '0;
      mix_enable   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_FREQ:   start_freq   <= pwdata;
        REG_STOP_FREQ:    stop_freq    <= pwdata;
        REG_SWEEP_RATE:   sweep_rate   <= pwdata;
        REG_PULSE_WIDTH:  pulse_width  <= pwdata;
        REG_PULSE_PERIOD: pulse_period <= pwdata;
        REG_SWEEP_MODE:   sweep_mode   <= pwdata[0];
        REG_GAIN:         gain         <= pwdata[GAIN_BITS-1:0];
        REG_MIX_ENABLE:   mix_enable   <= pwdata[0];
        default:          mix_enable   <= mix_enable;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_START_FREQ:   prdata = start_freq;
      REG_STOP_FREQ:    prdata = stop_freq;
      REG_SWEEP_RATE:   prdata = sweep_rate;
      REG_PULSE_WIDTH:  prdata = pulse_width;
      REG_PULSE_PERIOD: prdata = pulse_period;
      REG_SWEEP_MODE:   prdata = {31'd0, sweep_mode};
      REG_GAIN:         prdata = {{(32-GAIN_BITS){1'b0}}, gain};
      REG_MIX_ENABLE:   prdata = {31'd0, mix_enable};
      default:          prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage moves when it is empty or the next one moves.
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = v3;

  // Pulse gating for the accepted word.
  logic [31:0] cnt_inc;
  logic [31:0] pulse_count_next;
  logic        tone_on;

  always_comb begin
    cnt_inc = pulse_count + 32'd1;
    if (pulse_width == '0) begin
      pulse_count_next = pulse_count;
      tone_on          = 1'b1;
    end else begin
      pulse_count_next = (cnt_inc > pulse_period) ? '0 : cnt_inc;
      tone_on          = !(pulse_count_next > pulse_width);
    end
  end

  // Phase step and frequency ramp with saturation and end-of-sweep handling.
  logic signed [FREQ_BITS-1:0] freq_int;
  logic [PHASE_BITS-1:0]       phase_acc_next;
  logic signed [FREQ_BITS:0]   ramp_sum;
  logic signed [FREQ_BITS-1:0] ramped;
  logic signed [FREQ_BITS-1:0] stop_word;
  logic signed [FREQ_BITS-1:0] start_word;
  logic signed [FREQ_BITS-1:0] current_freq_next;
  logic                        ramp_active_next;

  always_comb begin
    freq_int       = current_freq >>> FREQ_FRAC_BITS;
    phase_acc_next = phase_acc + freq_int[PHASE_BITS-1:0];
    ramp_sum       = {current_freq[FREQ_BITS-1], current_freq} +
                     (FREQ_BITS+1)'(sweep_rate);
    if (ramp_sum[FREQ_BITS] != ramp_sum[FREQ_BITS-1]) begin
      ramped = ramp_sum[FREQ_BITS] ? F_MIN : F_MAX;
    end else begin
      ramped = ramp_sum[FREQ_BITS-1:0];
    end
    stop_word         = {stop_freq, {FREQ_FRAC_BITS{1'b0}}};
    start_word        = {start_freq, {FREQ_FRAC_BITS{1'b0}}};
    current_freq_next = ramp_active ? ramped : current_freq;
    ramp_active_next  = ramp_active;
    if (current_freq_next >= stop_word) begin
      if (sweep_mode) begin
        current_freq_next = start_word;
      end else begin
        ramp_active_next = 1'b0;
      end
    end
  end

  // Generator state: restart on any register write, advance per armed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      phase_acc    <= '0;
      current_freq <= '0;
      ramp_active  <= 1'b1;
      pulse_count  <= '0;
    end else if (cfg_wr) begin
      armed        <= 1'b1;
      phase_acc    <= '0;
      current_freq <= (cfg_idx == REG_START_FREQ) ?
                      {pwdata, {FREQ_FRAC_BITS{1'b0}}} : start_word;
      ramp_active  <= 1'b1;
      pulse_count  <= '0;
    end else if (accept && armed) begin
      phase_acc    <= phase_acc_next;
      current_freq <= current_freq_next;
      ramp_active  <= ramp_active_next;
      pulse_count  <= pulse_count_next;
    end
  end

  // Stage 1: capture the word and read both table taps.
  logic [1:0]                  quad;
  logic [TABLE_INDEX_BITS-1:0] tab_idx;
  logic [TABLE_INDEX_BITS:0]   tab_direct;
  logic [TABLE_INDEX_BITS:0]   tab_mirror;

  assign quad       = phase_acc[PHASE_BITS-1 -: 2];
  assign tab_idx    = phase_acc[PHASE_BITS-3 -: TABLE_INDEX_BITS];
  assign tab_direct = {1'b0, tab_idx};
  assign tab_mirror = (TABLE_INDEX_BITS+1)'(QN) - tab_direct;

  logic signed [SAMPLE_BITS-1:0] re1, im1;
  logic                          armed1, on1;
  logic [1:0]                    quad1;
  logic [MAG_BITS-1:0]           tab_r1, tab_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      re1    <= s_tdata[SAMPLE_BITS-1:0];
      im1    <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      armed1 <= armed;
      on1    <= tone_on;
      quad1  <= quad;
      tab_r1 <= QTAB[tab_direct];
      tab_m1 <= QTAB[tab_mirror];
    end
  end

  // Stage 2: pick cos and sin by quadrant, scale magnitudes by gain.
  logic [MAG_BITS-1:0] cos_mag, sin_mag;
  logic                cos_neg, sin_neg;
  logic [PROD_BITS-1:0] cos_prod, sin_prod;

  always_comb begin
    unique case (quad1)
      2'd0: begin
        cos_mag = tab_m1; cos_neg = 1'b0; sin_mag = tab_r1; sin_neg = 1'b0;
      end
      2'd1: begin
        cos_mag = tab_r1; cos_neg = 1'b1; sin_mag = tab_m1; sin_neg = 1'b0;
      end
      2'd2: begin
        cos_mag = tab_m1; cos_neg = 1'b1; sin_mag = tab_r1; sin_neg = 1'b1;
      end
      default: begin
        cos_mag = tab_r1; cos_neg = 1'b0; sin_mag = tab_m1; sin_neg = 1'b1;
      end
    endcase
    cos_prod = PROD_BITS'(cos_mag) * PROD_BITS'(gain) + PROD_BITS'(1 << (GAIN_BITS - 1));
    sin_prod = PROD_BITS'(sin_mag) * PROD_BITS'(gain) + PROD_BITS'(1 << (GAIN_BITS - 1));
  end

  logic signed [SAMPLE_BITS-1:0] re2, im2;
  logic                          armed2, on2, cos_neg2, sin_neg2;
  logic [MAG_BITS-1:0]           cos_sc2, sin_sc2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      re2      <= re1;
      im2      <= im1;
      armed2   <= armed1;
      on2      <= on1;
      cos_neg2 <= cos_neg;
      sin_neg2 <= sin_neg;
      cos_sc2  <= cos_prod[GAIN_BITS +: MAG_BITS];
      sin_sc2  <= sin_prod[GAIN_BITS +: MAG_BITS];
    end
  end

  // Stage 3: apply sign and gate, then mix with saturation or replace; pass through when unarmed.
  logic signed [SAMPLE_BITS:0]   tone_c, tone_s;
  logic signed [SAMPLE_BITS:0]   mix_c, mix_s;
  logic signed [SAMPLE_BITS-1:0] res_re, res_im;

  always_comb begin
    tone_c = '0;
    tone_s = '0;
    if (on2) begin
      tone_c = cos_neg2 ? -(SAMPLE_BITS+1)'(cos_sc2) : (SAMPLE_BITS+1)'(cos_sc2);
      tone_s = sin_neg2 ? -(SAMPLE_BITS+1)'(sin_sc2) : (SAMPLE_BITS+1)'(sin_sc2);
    end
    mix_c = (SAMPLE_BITS+1)'(re2) + tone_c;
    mix_s = (SAMPLE_BITS+1)'(im2) + tone_s;
    if (mix_c > SAT_MAX) begin
      mix_c = SAT_MAX;
    end else if (mix_c < SAT_MIN) begin
      mix_c = SAT_MIN;
    end
    if (mix_s > SAT_MAX) begin
      mix_s = SAT_MAX;
    end else if (mix_s < SAT_MIN) begin
      mix_s = SAT_MIN;
    end
    if (!armed2) begin
      res_re = re2;
      res_im = im2;
    end else if (mix_enable) begin
      res_re = mix_c[SAMPLE_BITS-1:0];
      res_im = mix_s[SAMPLE_BITS-1:0];
    end else begin
      res_re = tone_c[SAMPLE_BITS-1:0];
      res_im = tone_s[SAMPLE_BITS-1:0];
    end
  end

  logic [2*SAMPLE_BITS-1:0] out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      out_word <= {res_im, res_re};
    end
  end

  assign m_tdata = DATA_BITS'(out_word);

`ifndef NO_ASSERTIONS
  // A register write leaves the generator armed and restarted.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> armed && phase_acc == '0 && pulse_count == '0 && ramp_active)
    else $error("restart after register write failed");

  // The pulse timer never runs past the period once it has stepped.
  a_pulse_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && armed && pulse_width != '0 && !cfg_wr |=> pulse_count <= pulse_period)
    else $error("pulse timer exceeded period");

  // A finished single sweep holds its frequency.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ramp_active && !cfg_wr |=> $stable(current_freq))
    else $error("frequency moved after sweep end");

  // A result only reaches the output register from the stage before it.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(v3) |-> $past(v2))
    else $error("output word without a source");
`endif

endmodule
